// ===== rtl/core/spectrum_line_resampler_macros.svh =====
// spectrum_line_resampler_macros.svh: assertion macros for the resampler rtl
// depends on: nothing; included by the modules that carry assertions
`ifndef SPECTRUM_LINE_RESAMPLER_MACROS_SVH
`define SPECTRUM_LINE_RESAMPLER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SLR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define SLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/slr_pkg.sv =====
// slr_pkg: widths, register codes and reset values for the line resampler
// depends on: nothing
package slr_pkg;

  localparam int SRC_BITS     = 11;
  localparam int PTS_BITS     = 13;
  localparam int COL_BITS     = 12;
  localparam int BIN_IDX_BITS = 10;

  localparam int MAX_BINS_DEF   = 1024;
  localparam int LEVEL_BITS_DEF = 16;

  // register codes, taken from paddr bit 2
  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_POINT  = 1'b1;

  // item codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  localparam logic [SRC_BITS-1:0] SOURCE_RST = SRC_BITS'(1024);
  localparam logic [PTS_BITS-1:0] POINT_RST  = PTS_BITS'(1024);

endpackage

// ===== rtl/core/slr_div.sv =====
// slr_div: pipelined restoring divider, one quotient bit per register stage
// depends on: slr_pkg; quotient must be known to fit in QUO_W bits
module slr_div import slr_pkg::*; #(
  parameter int DEN_W  = PTS_BITS,
  parameter int QUO_W  = 10,
  parameter int SIDE_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [DEN_W+QUO_W-1:0]   num,
  input  logic [DEN_W-1:0]         den,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_vld,
  output logic [QUO_W-1:0]         quo,
  output logic [DEN_W-1:0]         rem,
  output logic [SIDE_W-1:0]        out_side
);

  logic              vld   [0:QUO_W];
  logic [DEN_W-1:0]  prem  [0:QUO_W];
  logic [QUO_W-1:0]  low   [0:QUO_W];
  logic [QUO_W-1:0]  pquo  [0:QUO_W];
  logic [SIDE_W-1:0] side  [0:QUO_W];

  // entry stage: upper bits form the first partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prem[0] <= num[DEN_W+QUO_W-1:QUO_W];
      low[0]  <= num[QUO_W-1:0];
      pquo[0] <= '0;
      side[0] <= in_side;
    end
  end

  // one compare and subtract per stage
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
      trial    = {prem[k], low[k][QUO_W-1]};
      fits     = trial >= {1'b0, den};
      rem_next = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prem[k+1] <= rem_next;
        low[k+1]  <= low[k] << 1;
        pquo[k+1] <= (pquo[k] << 1) | QUO_W'(fits);
        side[k+1] <= side[k];
      end
    end
  end

  assign out_vld  = vld[QUO_W];
  assign quo      = pquo[QUO_W];
  assign rem      = prem[QUO_W];
  assign out_side = side[QUO_W];

endmodule

// ===== rtl/core/slr_bins.sv =====
// slr_bins: bin store with one write port and two registered read ports
// depends on: slr_pkg
module slr_bins import slr_pkg::*; #(
  parameter int DEPTH  = MAX_BINS_DEF,
  parameter int LW     = LEVEL_BITS_DEF,
  parameter int SIDE_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [LW-1:0]            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_vld,
  output logic [LW-1:0]            lvl_a,
  output logic [LW-1:0]            lvl_b,
  output logic [SIDE_W-1:0]        out_side
);

  logic [LW-1:0] mem [0:DEPTH-1];

  // loads and reads pass this stage in item order, so no forwarding
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      lvl_a    <= mem[rd_addr_a];
      lvl_b    <= mem[rd_addr_b];
      out_side <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

endmodule

// ===== rtl/core/spectrum_line_resampler.sv =====
// Usage:
//   Request channel (req_valid/req_stall) takes load items (op = 0, write
//   bin_level to bin_index) and column requests (op = 1, column_index).
//   Result channel (res_valid/res_stall) gives one transfer per request:
//   column_level, column_echo and out_of_range; loads give none.
//   source_count and point_count are written over the APB-style port at
//   byte addresses 0 and 4; the user must write them only while the block
//   is idle, as the block itself does not enforce this. Throughput is one
//   item per cycle while the result channel is not stalled. The result
//   path runs through the two pipelined dividers: position over
//   point_count, then the weighted level difference over twice point_count.
//   Reset clears the valid bits and sets both counts to 1024; the bin store
//   holds no defined value until loaded.
//   A stalled result freezes the whole pipeline and raises req_stall in the
//   same cycle; nothing is lost or repeated.
// depends on: slr_pkg, slr_div, slr_bins, spectrum_line_resampler_macros.svh
`include "spectrum_line_resampler_macros.svh"
module spectrum_line_resampler import slr_pkg::*; #(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         op,
  input  logic [BIN_IDX_BITS-1:0]      bin_index,
  input  logic signed [LEVEL_BITS-1:0] bin_level,
  input  logic [COL_BITS-1:0]          column_index,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic signed [LEVEL_BITS-1:0] column_level,
  output logic [COL_BITS-1:0]          column_echo,
  output logic                         out_of_range,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW      = $clog2(MAX_BINS);
  localparam int QB1     = AW;
  localparam int NUM1_W  = PTS_BITS + QB1;
  localparam int POS_W   = COL_BITS + SRC_BITS;
  localparam int DEN2_W  = PTS_BITS + 1;
  localparam int QB2     = LEVEL_BITS + 3;
  localparam int NUM2_W  = DEN2_W + QB2;
  localparam int TW      = LEVEL_BITS + 15;
  localparam int CTL_W   = 1 + COL_BITS + 1 + 1;
  localparam int SIDE1_W = CTL_W + BIN_IDX_BITS + LEVEL_BITS;
  localparam int SIDEM_W = CTL_W + PTS_BITS;
  localparam int SIDE2_W = CTL_W + LEVEL_BITS;

  logic en;
  logic [SRC_BITS-1:0] source_count;
  logic [PTS_BITS-1:0] point_count;
  logic [SRC_BITS-1:0] s_eff;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= SOURCE_RST;
      point_count  <= POINT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SOURCE: source_count <= pwdata[SRC_BITS-1:0];
        REG_POINT:  point_count  <= pwdata[PTS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SOURCE: prdata = 32'(source_count);
      REG_POINT:  prdata = 32'(point_count);
      default:    prdata = '0;
    endcase
  end

  // the pipeline moves unless a finished result waits
  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;

  assign s_eff = (32'(source_count) > MAX_BINS) ? SRC_BITS'(MAX_BINS) : source_count;

  // entry stage: position product and flags
  logic                    v0;
  logic                    op0, oor0, zero0;
  logic [COL_BITS-1:0]     col0;
  logic [POS_W-1:0]        pos0;
  logic [BIN_IDX_BITS-1:0] bidx0;
  logic [LEVEL_BITS-1:0]   blvl0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0   <= op;
      col0  <= column_index;
      oor0  <= {1'b0, column_index} >= point_count;
      zero0 <= s_eff == '0;
      pos0  <= POS_W'(column_index) * POS_W'(s_eff);
      bidx0 <= bin_index;
      blvl0 <= bin_level;
    end
  end

  // position divided by point_count
  logic                  v1;
  logic [QB1-1:0]        prev1;
  logic [PTS_BITS-1:0]   rem1;
  logic [SIDE1_W-1:0]    side1;

  slr_div #(.DEN_W(PTS_BITS), .QUO_W(QB1), .SIDE_W(SIDE1_W)) u_div_pos (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v0),
    .num      (NUM1_W'(pos0)),
    .den      (point_count),
    .in_side  ({op0, col0, oor0, zero0, bidx0, blvl0}),
    .out_vld  (v1),
    .quo      (prev1),
    .rem      (rem1),
    .out_side (side1)
  );

  // unpack and pick interpolation or plain bin
  logic                    op1;
  logic [COL_BITS-1:0]     col1;
  logic                    oor1, zero1, interp1, wr_en1;
  logic [BIN_IDX_BITS-1:0] bidx1;
  logic [LEVEL_BITS-1:0]   blvl1;
  logic [PTS_BITS-1:0]     wgt1;

  always_comb begin
    {op1, col1, oor1, zero1, bidx1, blvl1} = side1;
    interp1 = ({2'b0, s_eff} < point_count) && ((32'(prev1) + 32'd1) < 32'(s_eff));
    wgt1    = interp1 ? rem1 : '0;
    wr_en1  = v1 && (op1 == OP_LOAD) && (32'(bidx1) < MAX_BINS);
  end

  // bin store read of both neighbours
  logic                  vm;
  logic [LEVEL_BITS-1:0] lvl_a, lvl_b;
  logic [SIDEM_W-1:0]    sidem;

  slr_bins #(.DEPTH(MAX_BINS), .LW(LEVEL_BITS), .SIDE_W(SIDEM_W)) u_bins (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (v1),
    .wr_en     (wr_en1),
    .wr_addr   (AW'(bidx1)),
    .wr_data   (blvl1),
    .rd_addr_a (prev1),
    .rd_addr_b (AW'(prev1 + QB1'(1))),
    .in_side   ({op1, col1, oor1, zero1, wgt1}),
    .out_vld   (vm),
    .lvl_a     (lvl_a),
    .lvl_b     (lvl_b),
    .out_side  (sidem)
  );

  // difference times weight; with no weight the far neighbour plays no part
  logic                    opm, oorm, zerom;
  logic [COL_BITS-1:0]     colm;
  logic [PTS_BITS-1:0]     wgtm;
  logic signed [LEVEL_BITS:0] diff;
  logic signed [TW-1:0]    t_next;
  logic                    vt;
  logic signed [TW-1:0]    t_m;
  logic [LEVEL_BITS-1:0]   a_t;
  logic [CTL_W-1:0]        ctl_t;

  always_comb begin
    {opm, colm, oorm, zerom, wgtm} = sidem;
    diff   = $signed({lvl_b[LEVEL_BITS-1], lvl_b}) - $signed({lvl_a[LEVEL_BITS-1], lvl_a});
    if (wgtm == '0) begin
      t_next = '0;
    end else begin
      t_next = diff * $signed({1'b0, wgtm});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (en) begin
      vt <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_m   <= t_next;
      a_t   <= lvl_a;
      ctl_t <= {opm, colm, oorm, zerom};
    end
  end

  // rounded quotient, offset so that the dividend stays positive
  logic signed [NUM2_W:0] t_ext, p_ext, nsum;

  always_comb begin
    t_ext = (NUM2_W+1)'(t_m);
    p_ext = $signed((NUM2_W+1)'(point_count));
    nsum  = (t_ext <<< 1) + p_ext + (p_ext <<< (LEVEL_BITS + 2));
  end

  logic                  v2;
  logic [QB2-1:0]        q2;
  logic [DEN2_W-1:0]     rem2;
  logic [SIDE2_W-1:0]    side2;

  slr_div #(.DEN_W(DEN2_W), .QUO_W(QB2), .SIDE_W(SIDE2_W)) u_div_wgt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vt),
    .num      (nsum[NUM2_W-1:0]),
    .den      ({point_count, 1'b0}),
    .in_side  ({ctl_t, a_t}),
    .out_vld  (v2),
    .quo      (q2),
    .rem      (rem2),
    .out_side (side2)
  );

  // output register; the offset is a multiple of the level range
  logic                  op2, oor2, zero2;
  logic [COL_BITS-1:0]   col2;
  logic [LEVEL_BITS-1:0] a2;
  logic [LEVEL_BITS-1:0] lvl2;

  always_comb begin
    {op2, col2, oor2, zero2, a2} = side2;
    lvl2 = (oor2 || zero2) ? '0 : LEVEL_BITS'(a2 + q2[LEVEL_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v2 && (op2 == OP_REQ);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      column_level <= lvl2;
      column_echo  <= col2;
      out_of_range <= oor2;
    end
  end

  `SLR_ASSERT_NOW(a_oor_zero, clk, rst, res_valid && out_of_range, column_level == '0)
  `SLR_ASSERT_NOW(a_stall_back, clk, rst, res_valid && res_stall, req_stall)
  `SLR_ASSERT_NEXT(a_freeze, clk, rst, vt && !en, $stable(t_m) && $stable(a_t))
  `SLR_ASSERT_NOW(a_rem_bound, clk, rst, v2 && (op2 == OP_REQ) && !oor2, rem2 < {point_count, 1'b0})

endmodule
